>>> sv/r2q_pkg.sv
// Shared types and constants for the resolver to quadrature encoder core.
// Holds field widths, register map, reset values and the CORDIC arctangent table.
// No dependencies.
package r2q_pkg;

    // Field widths fixed by the register map and result format
    localparam int OFS_W     = 12;
    localparam int GAIN_W    = 16;
    localparam int CPR_W     = 16;
    localparam int CAL_W     = 20;
    localparam int TOTAL_W   = CPR_W + 2;
    localparam int CAL_SHIFT = 8;

    // CORDIC datapath: calibrated value shifted up by 8, plus growth headroom
    localparam int XY_W  = 32;
    localparam int Z_W   = 34;
    localparam int TAB_W = 32;
    localparam int TAB_N = 24;

    // Configuration port
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam int CAL_MAX = (1 << (CAL_W - 1)) - 1;
    localparam int CAL_MIN = -(1 << (CAL_W - 1));

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1);

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_SIN_OFS  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COS_OFS  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIN_GAIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COS_GAIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CPR      = 3'd4;

    // Reset values
    localparam logic [OFS_W-1:0]         RST_OFS  = 12'd2048;
    localparam logic signed [GAIN_W-1:0] RST_GAIN = 16'sd2048;
    localparam logic [CPR_W-1:0]         RST_CPR  = 16'd500;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [TAB_W-1:0] ATAN_TAB [TAB_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic [OFS_W-1:0]         sin_ofs;
        logic [OFS_W-1:0]         cos_ofs;
        logic signed [GAIN_W-1:0] sin_gain;
        logic signed [GAIN_W-1:0] cos_gain;
        logic [CPR_W-1:0]         cpr;
    } cfg_t;

endpackage

>>> sv/r2q_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on r2q_pkg for the register map, widths and reset values.
module r2q_regs
    import r2q_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode a write word into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SIN_OFS:  cfg_next.sin_ofs  = pwdata[OFS_W-1:0];
                REG_COS_OFS:  cfg_next.cos_ofs  = pwdata[OFS_W-1:0];
                REG_SIN_GAIN: cfg_next.sin_gain = signed'(pwdata[GAIN_W-1:0]);
                REG_COS_GAIN: cfg_next.cos_gain = signed'(pwdata[GAIN_W-1:0]);
                REG_CPR:      cfg_next.cpr      = pwdata[CPR_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold registers, load reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sin_ofs  <= RST_OFS;
            cfg_reg.cos_ofs  <= RST_OFS;
            cfg_reg.sin_gain <= RST_GAIN;
            cfg_reg.cos_gain <= RST_GAIN;
            cfg_reg.cpr      <= RST_CPR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register, gains sign-extended
    always_comb
    begin
        unique case (idx)
            REG_SIN_OFS:  prdata = {{(DATA_W-OFS_W){1'b0}}, cfg_reg.sin_ofs};
            REG_COS_OFS:  prdata = {{(DATA_W-OFS_W){1'b0}}, cfg_reg.cos_ofs};
            REG_SIN_GAIN: prdata = {{(DATA_W-GAIN_W){cfg_reg.sin_gain[GAIN_W-1]}},
                                    cfg_reg.sin_gain};
            REG_COS_GAIN: prdata = {{(DATA_W-GAIN_W){cfg_reg.cos_gain[GAIN_W-1]}},
                                    cfg_reg.cos_gain};
            REG_CPR:      prdata = {{(DATA_W-CPR_W){1'b0}}, cfg_reg.cpr};
            default:      prdata = '0;
        endcase
    end

endmodule

>>> sv/r2q_cordic.sv
// Pipelined vectoring CORDIC: one register stage for the half-turn pre-rotation,
// then one stage per micro-rotation. Depends on r2q_pkg for widths and the atan table.
module r2q_cordic
    import r2q_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 40
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [CAL_W-1:0] in_y,
    input  logic signed [CAL_W-1:0] in_x,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic signed [Z_W-1:0]   out_z,
    output logic [SIDE_W-1:0]       out_side
);

    localparam logic signed [Z_W-1:0] HALF_TURN = {{(Z_W-TAB_W){1'b0}}, 32'h8000_0000};

    logic [STAGES:0]              v_reg;
    logic signed [XY_W-1:0]       x_reg    [0:STAGES];
    logic signed [XY_W-1:0]       y_reg    [0:STAGES];
    logic signed [Z_W-1:0]        z_reg    [0:STAGES];
    logic                         zero_reg [0:STAGES];
    logic [SIDE_W-1:0]            side_reg [0:STAGES];
    logic signed [XY_W-1:0]       x_next   [0:STAGES];
    logic signed [XY_W-1:0]       y_next   [0:STAGES];
    logic signed [Z_W-1:0]        z_next   [0:STAGES];
    logic signed [XY_W-1:0]       x_ext;
    logic signed [XY_W-1:0]       y_ext;

    assign x_ext = {{(XY_W-CAL_W-CAL_SHIFT){in_x[CAL_W-1]}}, in_x, {CAL_SHIFT{1'b0}}};
    assign y_ext = {{(XY_W-CAL_W-CAL_SHIFT){in_y[CAL_W-1]}}, in_y, {CAL_SHIFT{1'b0}}};

    // Pre-rotate a negative cosine by a half turn, then micro-rotate toward y = 0
    always_comb
    begin
        x_next[0] = x_ext;
        y_next[0] = y_ext;
        z_next[0] = '0;
        if (in_x[CAL_W-1])
        begin
            x_next[0] = -x_ext;
            y_next[0] = -y_ext;
            z_next[0] = in_y[CAL_W-1] ? -HALF_TURN : HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + signed'({{(Z_W-TAB_W){1'b0}}, ATAN_TAB[i]});
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - signed'({{(Z_W-TAB_W){1'b0}}, ATAN_TAB[i]});
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STAGES-1:0], in_valid};
        end
    end

    // Advance stage payload
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (in_x == '0) && (in_y == '0);
        side_reg[0] <= in_side;
        for (int i = 0; i <= STAGES; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            zero_reg[i+1] <= zero_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    // Force the angle of a zero vector to zero
    assign out_valid = v_reg[STAGES];
    assign out_z     = zero_reg[STAGES] ? '0 : z_reg[STAGES];
    assign out_side  = side_reg[STAGES];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(STAGES+1) out_valid)
        else $error("cordic word lost in pipeline");

    a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !x_reg[STAGES][XY_W-1])
        else $error("cordic x went negative");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_reg[STAGES]) |-> (x_reg[STAGES] == '0 && y_reg[STAGES] == '0))
        else $error("zero flag set on nonzero vector");

endmodule

>>> sv/resolver_to_quadrature_encoder_core.sv
// Throughput: one sample pair per cycle while busy is low; the CORDIC is unrolled
// into one register stage per micro-rotation, so a new word enters on every clock.
// Reset: asynchronous, active low; clears all valid bits and loads register defaults.
// busy is high during reset and for one cycle after; afterward it stays low.
// Results are shown for exactly one cycle with done; the receiver cannot stall.
module resolver_to_quadrature_encoder_core
    import r2q_pkg::*;
#(
    parameter int ADC_BITS      = 12,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [ADC_BITS-1:0]          sin_sample,
    input  logic [ADC_BITS-1:0]          cos_sample,
    output logic                         done,
    output logic signed [CAL_W-1:0]      sin_scaled,
    output logic signed [CAL_W-1:0]      cos_scaled,
    output logic signed [ANGLE_BITS-1:0] angle,
    output logic                         phase_a,
    output logic                         phase_b,
    output logic                         index_z
);

    localparam int DIFF_W  = ((ADC_BITS > OFS_W) ? ADC_BITS : OFS_W) + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W;
    localparam int RND_W   = PROD_W - CAL_SHIFT;
    localparam int SH      = TAB_W - ANGLE_BITS;
    localparam int SCALE_W = ANGLE_BITS + TOTAL_W;
    localparam int SIDE_W  = 2 * CAL_W;
    localparam int LAT     = CORDIC_STAGES + 7;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (CAL_SHIFT - 1);
    localparam logic signed [RND_W-1:0]  RND_MAX  = RND_W'(CAL_MAX);
    localparam logic signed [RND_W-1:0]  RND_MIN  = RND_W'(CAL_MIN);
    localparam logic signed [Z_W-1:0]    Z_HALF   = Z_W'(1) << (SH - 1);

    cfg_t cfg;

    logic                      busy_reg;
    logic                      acc;
    logic                      v1_reg, v2_reg, v3_reg, vr_reg, vm_reg, done_reg;
    logic signed [DIFF_W-1:0]  dsin_reg, dcos_reg, dsin_next, dcos_next;
    logic signed [GAIN_W-1:0]  sgain, cgain;
    logic signed [PROD_W-1:0]  psin_reg, pcos_reg;
    logic signed [CAL_W-1:0]   sin_cal_reg, cos_cal_reg;
    logic                      c_valid;
    logic signed [Z_W-1:0]     c_z;
    logic [SIDE_W-1:0]         c_side;
    logic signed [Z_W-1:0]     zsum;
    logic [ANGLE_BITS-1:0]     pos_reg, pos_m_reg;
    logic [SIDE_W-1:0]         side_r_reg, side_m_reg;
    logic [CPR_W-1:0]          cpr_eff;
    logic [TOTAL_W-1:0]        total;
    logic [SCALE_W-1:0]        scale_reg;
    logic [TOTAL_W-1:0]        idx;
    logic [SIDE_W-1:0]         side_o_reg;
    logic [ANGLE_BITS-1:0]     angle_reg;
    logic                      phase_a_reg, phase_b_reg, index_z_reg;

    // Round half up, drop the fraction, saturate to the calibrated range
    function automatic logic signed [CAL_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [RND_W-1:0]  r;
        s = p + RND_HALF;
        r = s[PROD_W-1:CAL_SHIFT];
        if (r > RND_MAX)
            return CAL_W'(CAL_MAX);
        else if (r < RND_MIN)
            return CAL_W'(CAL_MIN);
        else
            return r[CAL_W-1:0];
    endfunction

    r2q_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign acc  = start && !busy_reg;
    assign busy = busy_reg;

    // Subtract offsets; apply zero-gain substitution
    assign dsin_next = signed'(DIFF_W'(sin_sample) - DIFF_W'(cfg.sin_ofs));
    assign dcos_next = signed'(DIFF_W'(cos_sample) - DIFF_W'(cfg.cos_ofs));
    assign sgain     = (cfg.sin_gain == '0) ? GAIN_ONE : cfg.sin_gain;
    assign cgain     = (cfg.cos_gain == '0) ? GAIN_ONE : cfg.cos_gain;

    r2q_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_y      (sin_cal_reg),
        .in_x      (cos_cal_reg),
        .in_side   ({sin_cal_reg, cos_cal_reg}),
        .out_valid (c_valid),
        .out_z     (c_z),
        .out_side  (c_side)
    );

    // Round the turn angle to ANGLE_BITS; scale by four times counts per turn
    assign zsum    = c_z + Z_HALF;
    assign cpr_eff = (cfg.cpr == '0) ? CPR_W'(1) : cfg.cpr;
    assign total   = {cpr_eff, 2'b00};

    // Drop the fraction of the state index; clamp to the last state
    always_comb
    begin
        idx = scale_reg[ANGLE_BITS +: TOTAL_W];
        if (idx >= total)
            idx = total - TOTAL_W'(1);
    end

    // Hold control: valid bits and startup busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vr_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v1_reg   <= acc;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vr_reg   <= c_valid;
            vm_reg   <= vr_reg;
            done_reg <= vm_reg;
        end
    end

    // Advance payload through calibration and the output stages
    always_ff @(posedge clk)
    begin
        dsin_reg    <= dsin_next;
        dcos_reg    <= dcos_next;
        psin_reg    <= dsin_reg * sgain;
        pcos_reg    <= dcos_reg * cgain;
        sin_cal_reg <= round_sat(psin_reg);
        cos_cal_reg <= round_sat(pcos_reg);
        pos_reg     <= zsum[SH +: ANGLE_BITS];
        side_r_reg  <= c_side;
        scale_reg   <= SCALE_W'(pos_reg) * SCALE_W'(total);
        pos_m_reg   <= pos_reg;
        side_m_reg  <= side_r_reg;
        angle_reg   <= pos_m_reg;
        side_o_reg  <= side_m_reg;
        phase_a_reg <= idx[0] ^ idx[1];
        phase_b_reg <= idx[1];
        index_z_reg <= (idx[TOTAL_W-1:2] == '0);
    end

    assign done       = done_reg;
    assign sin_scaled = side_o_reg[SIDE_W-1:CAL_W];
    assign cos_scaled = side_o_reg[CAL_W-1:0];
    assign angle      = signed'(angle_reg);
    assign phase_a    = phase_a_reg;
    assign phase_b    = phase_b_reg;
    assign index_z    = index_z_reg;

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##LAT done)
        else $error("accepted word did not produce a result");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, LAT))
        else $error("result without an accepted word");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && sin_scaled == '0 && cos_scaled == '0)
            |-> (angle == '0 && index_z && !phase_a && !phase_b))
        else $error("zero vector gave nonzero angle or state");

endmodule
